// ===== hw/rtl/aplt_pkg.sv =====
// Shared types and constants for the aging port learning table.
// No dependencies; compiled first.
`default_nettype none

package aplt_pkg;

    localparam int OP_W      = 3;
    localparam int KEY_W     = 24;
    localparam int TAG_W     = KEY_W + 1;
    localparam int PORT_W    = 4;
    localparam int TIME_W    = 48;
    localparam int AGE_W     = 32;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    localparam int DEPTH_DEFAULT = 64;
    localparam int PORT_COUNT    = 16;
    localparam int PORT_CMP_W    = 9;

    localparam logic [AGE_W-1:0]  AGING_RESET = AGE_W'(300);
    localparam logic [TIME_W-1:0] TIME_MAX    = '1;

    // opcodes
    localparam logic [OP_W-1:0] OP_TICK       = 3'd0;
    localparam logic [OP_W-1:0] OP_LEARN_PFX  = 3'd1;
    localparam logic [OP_W-1:0] OP_LEARN_SFX  = 3'd2;
    localparam logic [OP_W-1:0] OP_PIN_PFX    = 3'd3;
    localparam logic [OP_W-1:0] OP_LOOKUP_PFX = 3'd4;
    localparam logic [OP_W-1:0] OP_LOOKUP_SFX = 3'd5;

    // register index (word address bit above the byte offset)
    localparam logic REG_AGING = 1'b0;

    // one table slot; tag bit 24 marks a host suffix
    typedef struct packed {
        logic              valid;
        logic              pinned;
        logic [TAG_W-1:0]  tag;
        logic [PORT_W-1:0] port;
        logic [TIME_W-1:0] expiry;
    } slot_t;

    typedef struct packed {
        logic load;
        logic clr_wr;
        logic rd_en;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic cnt_last;
        logic needs_scan;
    } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/aplt_if.sv =====
// Valid/ready channel interfaces for the learning table item and result beats.
// Depends on aplt_pkg.
`default_nettype none

interface aplt_in_if import aplt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [KEY_W-1:0]  key;
    logic [PORT_W-1:0] port;

    modport source (output valid, opcode, key, port, input ready);
    modport sink   (input valid, opcode, key, port, output ready);
endinterface

interface aplt_out_if import aplt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              hit;
    logic [PORT_W-1:0] out_port;
    logic              status;

    modport source (output valid, hit, out_port, status, input ready);
    modport sink   (input valid, hit, out_port, status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/aplt_ctrl.sv =====
// Sequencer for the learning table: clear sweep, slot scan, commit, result beat.
// Depends on aplt_pkg.
`default_nettype none

module aplt_ctrl import aplt_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output cmd_t      cmd,
    input  wire sts_t sts
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.cnt_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.needs_scan ? S_SCAN : S_DECIDE;
                end
            end
            S_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (sts.cnt_last)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // one item in flight
    a_load_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !in_ready)
        else $error("input accepted again before commit");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid)
        else $error("commit did not produce a result beat");

    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_CLEAR) |=> (state_reg != S_CLEAR))
        else $error("clear sweep restarted");

endmodule

`default_nettype wire

// ===== hw/rtl/aplt_dp.sv =====
// Learning table datapath: slot memory, scan trackers, time counter, result register.
// Depends on aplt_pkg; driven by aplt_ctrl commands.
`default_nettype none

module aplt_dp import aplt_pkg::*; #(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cmd_t              cmd,
    output sts_t                   sts,
    input  wire logic [OP_W-1:0]   in_opcode,
    input  wire logic [KEY_W-1:0]  in_key,
    input  wire logic [PORT_W-1:0] in_port,
    input  wire logic [AGE_W-1:0]  aging_ticks,
    output logic                   hit,
    output logic [PORT_W-1:0]      out_port,
    output logic                   status
);

    localparam int AW = $clog2(TABLE_DEPTH);

    slot_t mem [TABLE_DEPTH];

    // control state
    logic [AW-1:0]     cnt_reg, cnt_next;
    logic              eval_vld_reg;
    logic [TIME_W-1:0] now_reg, now_next;
    logic              m_found_reg, inv_found_reg, exp_found_reg;

    // payload
    slot_t             rd_word_reg;
    logic [AW-1:0]     eval_idx_reg;
    logic [OP_W-1:0]   op_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [PORT_W-1:0] port_reg;
    logic [TIME_W-1:0] new_exp_reg, new_exp_next;
    logic [AW-1:0]     m_idx_reg, inv_idx_reg, exp_idx_reg;
    logic [PORT_W-1:0] m_port_reg;
    logic              m_pinned_reg, m_live_reg;
    logic [TIME_W-1:0] m_exp_reg;
    logic              hit_reg, hit_next;
    logic [PORT_W-1:0] out_port_reg, out_port_next;
    logic              status_reg, status_next;

    logic [TIME_W:0]   exp_sum;
    logic              in_sfx;
    logic              ev_match, ev_inv, ev_exp, ev_after_now;
    logic              is_learn, is_pin, is_lookup, port_ok, free_ok;
    logic [AW-1:0]     free_idx;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    slot_t             wr_word;

    assign sts.cnt_last   = (cnt_reg == AW'(TABLE_DEPTH - 1));
    assign sts.needs_scan = (in_opcode == OP_LEARN_PFX) || (in_opcode == OP_LEARN_SFX)
                         || (in_opcode == OP_PIN_PFX)   || (in_opcode == OP_LOOKUP_PFX)
                         || (in_opcode == OP_LOOKUP_SFX);

    assign in_sfx       = (in_opcode == OP_LEARN_SFX) || (in_opcode == OP_LOOKUP_SFX);
    assign exp_sum      = {1'b0, now_reg} + (TIME_W + 1)'(aging_ticks);
    assign new_exp_next = exp_sum[TIME_W] ? TIME_MAX : exp_sum[TIME_W-1:0];

    // per-slot evaluation, one slot a cycle
    assign ev_after_now = rd_word_reg.expiry > now_reg;
    assign ev_match     = rd_word_reg.valid && (rd_word_reg.tag == tag_reg);
    assign ev_inv       = !rd_word_reg.valid;
    assign ev_exp       = rd_word_reg.valid && !rd_word_reg.pinned && !ev_after_now;

    assign is_learn  = (op_reg == OP_LEARN_PFX) || (op_reg == OP_LEARN_SFX);
    assign is_pin    = (op_reg == OP_PIN_PFX);
    assign is_lookup = (op_reg == OP_LOOKUP_PFX) || (op_reg == OP_LOOKUP_SFX);
    assign port_ok   = {{(PORT_CMP_W - PORT_W){1'b0}}, port_reg} < PORT_CMP_W'(PORT_COUNT);
    assign free_ok   = inv_found_reg || exp_found_reg;
    assign free_idx  = inv_found_reg ? inv_idx_reg : exp_idx_reg;

    assign cnt_next = cmd.load ? '0
                    : ((cmd.rd_en || cmd.clr_wr) ? cnt_reg + AW'(1) : cnt_reg);

    always_comb
    begin
        wr_en          = 1'b0;
        wr_addr        = free_idx;
        wr_word.valid  = 1'b1;
        wr_word.pinned = 1'b0;
        wr_word.tag    = tag_reg;
        wr_word.port   = port_reg;
        wr_word.expiry = new_exp_reg;
        hit_next       = 1'b0;
        out_port_next  = '0;
        status_next    = 1'b0;
        now_next       = now_reg;
        if (cmd.clr_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = cnt_reg;
            wr_word = '0;
        end
        else if (cmd.commit)
        begin
            priority if (op_reg == OP_TICK)
            begin
                if (now_reg != TIME_MAX)
                    now_next = now_reg + TIME_W'(1);
            end
            else if (is_learn && port_ok)
            begin
                if (m_found_reg)
                begin
                    wr_addr = m_idx_reg;
                    wr_en   = !m_pinned_reg && (new_exp_reg > m_exp_reg);
                end
                else if (free_ok)
                    wr_en = 1'b1;
                else
                    status_next = 1'b1;
            end
            else if (is_pin && port_ok)
            begin
                wr_word.pinned = 1'b1;
                wr_word.expiry = TIME_MAX;
                if (m_found_reg)
                begin
                    wr_addr = m_idx_reg;
                    wr_en   = 1'b1;
                end
                else if (free_ok)
                    wr_en = 1'b1;
                else
                    status_next = 1'b1;
            end
            else if (is_lookup)
            begin
                if (m_found_reg && m_live_reg)
                begin
                    hit_next      = 1'b1;
                    out_port_next = m_port_reg;
                end
            end
            else
            begin
                // unused opcode or port out of range: all-zero answer
            end
        end
    end

    // slot memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_word;
        if (cmd.rd_en)
            rd_word_reg <= mem[cnt_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            eval_vld_reg  <= 1'b0;
            now_reg       <= '0;
            m_found_reg   <= 1'b0;
            inv_found_reg <= 1'b0;
            exp_found_reg <= 1'b0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            eval_vld_reg <= cmd.rd_en;
            now_reg      <= now_next;
            if (cmd.load)
            begin
                m_found_reg   <= 1'b0;
                inv_found_reg <= 1'b0;
                exp_found_reg <= 1'b0;
            end
            else if (eval_vld_reg)
            begin
                if (ev_match)
                    m_found_reg <= 1'b1;
                if (ev_inv)
                    inv_found_reg <= 1'b1;
                if (ev_exp)
                    exp_found_reg <= 1'b1;
            end
        end
    end

    // payload registers; lowest index wins since the scan ascends
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
            eval_idx_reg <= cnt_reg;
        if (cmd.load)
        begin
            op_reg      <= in_opcode;
            tag_reg     <= {in_sfx, in_key};
            port_reg    <= in_port;
            new_exp_reg <= new_exp_next;
        end
        if (eval_vld_reg && !cmd.load)
        begin
            if (ev_match && !m_found_reg)
            begin
                m_idx_reg    <= eval_idx_reg;
                m_port_reg   <= rd_word_reg.port;
                m_pinned_reg <= rd_word_reg.pinned;
                m_exp_reg    <= rd_word_reg.expiry;
                m_live_reg   <= rd_word_reg.pinned || ev_after_now;
            end
            if (ev_inv && !inv_found_reg)
                inv_idx_reg <= eval_idx_reg;
            if (ev_exp && !exp_found_reg)
                exp_idx_reg <= eval_idx_reg;
        end
        if (cmd.commit)
        begin
            hit_reg      <= hit_next;
            out_port_reg <= out_port_next;
            status_reg   <= status_next;
        end
    end

    assign hit      = hit_reg;
    assign out_port = out_port_reg;
    assign status   = status_reg;

    a_now_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (now_reg >= $past(now_reg)))
        else $error("time counter went backward");

    a_pin_never_ages: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && wr_word.pinned) |-> (wr_word.expiry == TIME_MAX))
        else $error("pinned slot written with finite expiry");

    a_hit_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> !(hit && status))
        else $error("lookup hit reported together with a drop");

endmodule

`default_nettype wire

// ===== hw/rtl/aging_port_learning_table_top.sv =====
// Top level of the aging port learning table: channels, APB register, ctrl + datapath.
// Depends on aplt_pkg, aplt_if, aplt_ctrl, aplt_dp.
//
// Usage:
//  - in_ch carries one operation per beat (opcode, key, port); out_ch returns
//    exactly one result beat (hit, out_port, status) per accepted operation.
//  - Lookups, learns and pins scan every slot of the slot memory through its
//    single read port, one slot per cycle, then commit; the next beat is
//    taken only after the commit, so one operation is in flight at a time.
//  - Ticks and unused opcodes skip the scan and go straight to the commit.
//  - After reset the block sweeps the slot memory clear, one slot a cycle;
//    in_ch.ready stays low until that ends. Time restarts at zero and
//    aging_ticks returns to 300.
//  - The result sits in an output register. While out_ch is stalled the
//    block still accepts and scans the next operation; it holds before its
//    commit until the pending result beat is taken.
//  - aging_ticks at APB byte address 0; write only while idle.
`default_nettype none

module aging_port_learning_table_top import aplt_pkg::*; #(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    aplt_in_if.sink                in_ch,
    aplt_out_if.source             out_ch,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    cmd_t             cmd;
    sts_t             sts;
    logic [AGE_W-1:0] aging_reg;
    logic             reg_sel;

    // register index is the word address above the byte offset
    assign reg_sel = (paddr[APB_AW-1] == REG_AGING);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? aging_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            aging_reg <= AGING_RESET;
        else if (psel && penable && pwrite && reg_sel)
            aging_reg <= pwdata;
    end

    // sequencer: clear sweep, scan, commit, result handshake
    aplt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // slot memory, trackers, time counter and result register
    aplt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_opcode   (in_ch.opcode),
        .in_key      (in_ch.key),
        .in_port     (in_ch.port),
        .aging_ticks (aging_reg),
        .hit         (out_ch.hit),
        .out_port    (out_ch.out_port),
        .status      (out_ch.status)
    );

endmodule

`default_nettype wire
